// ===== hdl/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared types, token tags and character tables of the token lexer.
// ----------------------------------------------------------------------------
package tdl_pkg;

    localparam int DEF_POSITION_BITS = 32;
    localparam int DEF_LENGTH_BITS   = 16;
    localparam int KEYWORD_BYTES     = 8;
    localparam int KW_IDX_W          = $clog2(KEYWORD_BYTES);
    localparam int CHARS_W           = 8 * KEYWORD_BYTES;
    localparam int QUEUE_DEPTH       = 4;
    localparam int TAG_W             = 6;
    localparam int OFFSET_W          = 32;
    localparam int LEN_W             = 16;

    typedef logic [TAG_W-1:0] tag_t;

    localparam tag_t TAG_ASSIGN    = 6'd0;
    localparam tag_t TAG_COMMA     = 6'd1;
    localparam tag_t TAG_DOT       = 6'd2;
    localparam tag_t TAG_COLON     = 6'd3;
    localparam tag_t TAG_SEMICOLON = 6'd4;
    localparam tag_t TAG_LBRACE    = 6'd5;
    localparam tag_t TAG_RBRACE    = 6'd6;
    localparam tag_t TAG_LBRACKET  = 6'd7;
    localparam tag_t TAG_RBRACKET  = 6'd8;
    localparam tag_t TAG_LPAREN    = 6'd9;
    localparam tag_t TAG_RPAREN    = 6'd10;
    localparam tag_t TAG_ADD       = 6'd11;
    localparam tag_t TAG_SUB       = 6'd12;
    localparam tag_t TAG_MUL       = 6'd13;
    localparam tag_t TAG_DIV       = 6'd14;
    localparam tag_t TAG_NEG       = 6'd15;
    localparam tag_t TAG_EQ        = 6'd16;
    localparam tag_t TAG_NE        = 6'd17;
    localparam tag_t TAG_GE        = 6'd18;
    localparam tag_t TAG_GT        = 6'd19;
    localparam tag_t TAG_LE        = 6'd20;
    localparam tag_t TAG_LT        = 6'd21;
    localparam tag_t TAG_AND       = 6'd22;
    localparam tag_t TAG_CASE      = 6'd23;
    localparam tag_t TAG_DO        = 6'd24;
    localparam tag_t TAG_ELIF      = 6'd25;
    localparam tag_t TAG_ELSE      = 6'd26;
    localparam tag_t TAG_END       = 6'd27;
    localparam tag_t TAG_FOR       = 6'd28;
    localparam tag_t TAG_FUNCTION  = 6'd29;
    localparam tag_t TAG_IF        = 6'd30;
    localparam tag_t TAG_LET       = 6'd31;
    localparam tag_t TAG_OR        = 6'd32;
    localparam tag_t TAG_THEN      = 6'd33;
    localparam tag_t TAG_WHILE     = 6'd34;
    localparam tag_t TAG_ID        = 6'd35;
    localparam tag_t TAG_NUM       = 6'd36;
    localparam tag_t TAG_EOF       = 6'd37;
    localparam tag_t TAG_ILLEGAL   = 6'd38;

    typedef enum logic [3:0] {
        CL_OTHER,
        CL_ALPHA,
        CL_DIGIT,
        CL_HASH,
        CL_MINUS,
        CL_NL,
        CL_NUL,
        CL_OP,
        CL_PUNCT,
        CL_BLANK
    } class_t;

    typedef struct packed {
        logic [7:0] data;
        class_t     cls;
    } item_t;

    typedef struct packed {
        tag_t                tag;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    len;
        logic                last;
    } token_t;

    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        if (b == 8'h00)
            c = CL_NUL;
        else if (b == 8'h0A)
            c = CL_NL;
        else if (b == 8'h09 || b == " ")
            c = CL_BLANK;
        else if (b == "#")
            c = CL_HASH;
        else if (b == "-")
            c = CL_MINUS;
        else if (b inside {["0":"9"]})
            c = CL_DIGIT;
        else if (b inside {["a":"z"], ["A":"Z"], "_"})
            c = CL_ALPHA;
        else if (b inside {"!", "$", "%", "&", "*", "+", "/", "<", "=", ">",
                           "?", "@", "^", "|", "~"})
            c = CL_OP;
        else if (b inside {"(", ")", ",", ".", ":", ";", "[", "]", "{", "}"})
            c = CL_PUNCT;
        else
            c = CL_OTHER;
        return c;
    endfunction

    function automatic tag_t punct_tag(input logic [7:0] b);
        tag_t t;
        case (b)
            ",":     t = TAG_COMMA;
            ".":     t = TAG_DOT;
            ":":     t = TAG_COLON;
            ";":     t = TAG_SEMICOLON;
            "{":     t = TAG_LBRACE;
            "}":     t = TAG_RBRACE;
            "[":     t = TAG_LBRACKET;
            "]":     t = TAG_RBRACKET;
            "(":     t = TAG_LPAREN;
            ")":     t = TAG_RPAREN;
            default: t = TAG_ILLEGAL;
        endcase
        return t;
    endfunction

    // one/two: span length is exactly one or two bytes
    function automatic tag_t op_tag(input logic [7:0] c0, input logic [7:0] c1,
                                    input logic one, input logic two);
        tag_t t;
        t = TAG_ILLEGAL;
        if (one)
        begin
            case (c0)
                "=":     t = TAG_ASSIGN;
                "+":     t = TAG_ADD;
                "-":     t = TAG_SUB;
                "*":     t = TAG_MUL;
                "~":     t = TAG_NEG;
                "/":     t = TAG_DIV;
                "<":     t = TAG_LT;
                ">":     t = TAG_GT;
                default: t = TAG_ILLEGAL;
            endcase
        end
        else if (two && c1 == "=")
        begin
            case (c0)
                "=":     t = TAG_EQ;
                "!":     t = TAG_NE;
                "<":     t = TAG_LE;
                ">":     t = TAG_GE;
                default: t = TAG_ILLEGAL;
            endcase
        end
        return t;
    endfunction

    // chars holds the first byte of the identifier in its top byte
    function automatic tag_t ident_tag(input logic [CHARS_W-1:0] chars,
                                       input logic [3:0] len);
        tag_t t;
        t = TAG_ID;
        case (len)
            4'd2:
            begin
                if (chars[CHARS_W-1 -: 16] == "do")
                    t = TAG_DO;
                else if (chars[CHARS_W-1 -: 16] == "if")
                    t = TAG_IF;
                else if (chars[CHARS_W-1 -: 16] == "or")
                    t = TAG_OR;
            end
            4'd3:
            begin
                if (chars[CHARS_W-1 -: 24] == "and")
                    t = TAG_AND;
                else if (chars[CHARS_W-1 -: 24] == "end")
                    t = TAG_END;
                else if (chars[CHARS_W-1 -: 24] == "for")
                    t = TAG_FOR;
                else if (chars[CHARS_W-1 -: 24] == "let")
                    t = TAG_LET;
            end
            4'd4:
            begin
                if (chars[CHARS_W-1 -: 32] == "case")
                    t = TAG_CASE;
                else if (chars[CHARS_W-1 -: 32] == "elif")
                    t = TAG_ELIF;
                else if (chars[CHARS_W-1 -: 32] == "else")
                    t = TAG_ELSE;
                else if (chars[CHARS_W-1 -: 32] == "then")
                    t = TAG_THEN;
            end
            4'd5:
            begin
                if (chars[CHARS_W-1 -: 40] == "while")
                    t = TAG_WHILE;
            end
            4'd8:
            begin
                if (chars[CHARS_W-1 -: 64] == "function")
                    t = TAG_FUNCTION;
            end
            default: t = TAG_ID;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/tdl_front.sv =====
// ----------------------------------------------------------------------------
// tdl_front
// Input stage: accepts source bytes and registers each with its class.
// ----------------------------------------------------------------------------
module tdl_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    output logic           out_valid,
    input  logic           out_ready,
    output tdl_pkg::item_t out_item
);
    import tdl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data <= in_byte;
            item_reg.cls  <= classify(in_byte);
        end
    end

endmodule

// ===== hdl/tdl_queue.sv =====
// ----------------------------------------------------------------------------
// tdl_queue
// Short FIFO of classified bytes between the input stage and the lexer core.
// ----------------------------------------------------------------------------
module tdl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tdl_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tdl_pkg::item_t pop_item
);
    import tdl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hdl/tdl_back.sv =====
// ----------------------------------------------------------------------------
// tdl_back
// Lexer core: steps the mode machine one byte at a time and emits tokens
// through an output register plus one holding slot for a second token.
// ----------------------------------------------------------------------------
module tdl_back #(
    parameter int POSITION_BITS = tdl_pkg::DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = tdl_pkg::DEF_LENGTH_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tdl_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tdl_pkg::token_t out_token
);
    import tdl_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] KW_LIMIT = LENGTH_BITS'(KEYWORD_BYTES);

    typedef enum logic [2:0] {
        M_START,
        M_IDENT,
        M_MINUS,
        M_NUMBER,
        M_OPSPAN,
        M_COMMENT
    } mode_t;

    mode_t                    mode_reg;
    mode_t                    mode_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] begin_reg;
    logic [POSITION_BITS-1:0] begin_next;
    logic [LENGTH_BITS-1:0]   count_reg;
    logic [LENGTH_BITS-1:0]   count_next;
    logic                     out_v_reg;
    logic                     out_v_next;
    token_t                   out_reg;
    token_t                   out_next;
    logic                     pend_v_reg;
    logic                     pend_v_next;
    token_t                   pend_reg;
    token_t                   pend_next;

    logic [7:0]               lead_mem [KEYWORD_BYTES];
    logic                     lead_we;
    logic [KW_IDX_W-1:0]      lead_idx;
    logic [CHARS_W-1:0]       chars;
    logic [3:0]               kw_len;

    logic                     take;
    logic                     keep;
    mode_t                    keep_mode;
    logic                     span_mode;
    logic                     run_start;
    tag_t                     span_tag;
    logic                     fl_v;
    token_t                   fl_tok;
    logic                     st_v;
    token_t                   st_tok;
    logic                     tok0_v;
    token_t                   tok0;
    logic                     tok1_v;
    token_t                   tok1;
    logic [POSITION_BITS-1:0] pos_inc;

    assign in_ready  = !pend_v_reg && (!out_v_reg || out_ready);
    assign take      = in_valid && in_ready;
    assign out_valid = out_v_reg;
    assign out_token = out_reg;
    assign pos_inc   = pos_reg + POSITION_BITS'(1);

    // pack leading bytes with the first one on top for keyword compare
    always_comb
    begin
        for (int i = 0; i < KEYWORD_BYTES; i++)
            chars[CHARS_W-1-8*i -: 8] = lead_mem[i];
        kw_len = (count_reg <= KW_LIMIT) ? 4'(count_reg) : 4'd0;
    end

    // classify the pending span against this byte
    always_comb
    begin
        keep      = 1'b0;
        keep_mode = M_START;
        span_mode = 1'b1;
        span_tag  = TAG_ILLEGAL;
        case (mode_reg)
            M_IDENT:
            begin
                keep      = in_item.cls == CL_ALPHA || in_item.cls == CL_DIGIT;
                keep_mode = M_IDENT;
                span_tag  = ident_tag(chars, kw_len);
            end
            M_MINUS:
            begin
                if (in_item.cls == CL_DIGIT)
                begin
                    keep      = 1'b1;
                    keep_mode = M_NUMBER;
                end
                else if (in_item.cls == CL_MINUS || in_item.cls == CL_OP)
                begin
                    keep      = 1'b1;
                    keep_mode = M_OPSPAN;
                end
                span_tag = op_tag(lead_mem[0], lead_mem[1],
                                  count_reg == LENGTH_BITS'(1),
                                  count_reg == LENGTH_BITS'(2));
            end
            M_NUMBER:
            begin
                keep      = in_item.cls == CL_DIGIT;
                keep_mode = M_NUMBER;
                span_tag  = TAG_NUM;
            end
            M_OPSPAN:
            begin
                keep      = in_item.cls == CL_MINUS || in_item.cls == CL_OP;
                keep_mode = M_OPSPAN;
                span_tag  = op_tag(lead_mem[0], lead_mem[1],
                                   count_reg == LENGTH_BITS'(1),
                                   count_reg == LENGTH_BITS'(2));
            end
            default:
                span_mode = 1'b0;
        endcase
    end

    // lexer step
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        count_next = count_reg;
        lead_we    = 1'b0;
        lead_idx   = count_reg[KW_IDX_W-1:0];
        run_start  = 1'b0;
        fl_v       = 1'b0;
        fl_tok     = '{tag: span_tag, offset: OFFSET_W'(begin_reg),
                       len: LEN_W'(count_reg), last: 1'b0};
        st_v       = 1'b0;
        st_tok     = '{tag: TAG_ILLEGAL, offset: OFFSET_W'(pos_reg),
                       len: LEN_W'(1), last: 1'b1};

        if (span_mode)
        begin
            if (keep)
            begin
                lead_we   = count_reg < KW_LIMIT;
                if (count_reg != LEN_MAX)
                    count_next = count_reg + LENGTH_BITS'(1);
                mode_next = keep_mode;
                pos_next  = pos_inc;
            end
            else
            begin
                fl_v      = 1'b1;
                run_start = 1'b1;
            end
        end
        else if (mode_reg == M_COMMENT)
        begin
            if (in_item.cls == CL_NUL)
                run_start = 1'b1;
            else
            begin
                if (in_item.cls == CL_NL)
                    mode_next = M_START;
                pos_next = pos_inc;
            end
        end
        else
            run_start = 1'b1;

        // re-lex the byte from start mode
        if (run_start)
        begin
            mode_next = M_START;
            case (in_item.cls)
                CL_ALPHA, CL_DIGIT, CL_MINUS, CL_OP:
                begin
                    begin_next = pos_reg;
                    count_next = LENGTH_BITS'(1);
                    lead_we    = 1'b1;
                    lead_idx   = '0;
                    pos_next   = pos_inc;
                    case (in_item.cls)
                        CL_ALPHA: mode_next = M_IDENT;
                        CL_DIGIT: mode_next = M_NUMBER;
                        CL_MINUS: mode_next = M_MINUS;
                        default:  mode_next = M_OPSPAN;
                    endcase
                end
                CL_HASH:
                begin
                    mode_next = M_COMMENT;
                    pos_next  = pos_inc;
                end
                CL_NL, CL_BLANK:
                    pos_next = pos_inc;
                CL_NUL:
                begin
                    st_v       = 1'b1;
                    st_tok.tag = TAG_EOF;
                    st_tok.len = '0;
                    pos_next   = '0;
                    count_next = '0;
                end
                CL_PUNCT:
                begin
                    st_v       = 1'b1;
                    st_tok.tag = punct_tag(in_item.data);
                    pos_next   = pos_inc;
                end
                default:
                begin
                    st_v     = 1'b1;
                    pos_next = pos_inc;
                end
            endcase
        end

        tok0_v    = fl_v || st_v;
        tok0      = fl_v ? fl_tok : st_tok;
        tok0.last = !(fl_v && st_v);
        tok1_v    = fl_v && st_v;
        tok1      = st_tok;
    end

    // output register and second-token slot
    always_comb
    begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        if (take)
        begin
            out_v_next  = tok0_v;
            out_next    = tok0;
            pend_v_next = tok1_v;
            pend_next   = tok1;
        end
        else if (!out_v_reg || out_ready)
        begin
            out_v_next  = pend_v_reg;
            out_next    = pend_reg;
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_START;
            pos_reg    <= '0;
            begin_reg  <= '0;
            count_reg  <= '0;
            out_v_reg  <= 1'b0;
            out_reg    <= '0;
            pend_v_reg <= 1'b0;
            pend_reg   <= '0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                begin_reg <= begin_next;
                count_reg <= count_next;
            end
            out_v_reg  <= out_v_next;
            out_reg    <= out_next;
            pend_v_reg <= pend_v_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && lead_we)
            lead_mem[lead_idx] <= in_item.data;
    end

endmodule

// ===== hdl/table_driven_token_lexer_top.sv =====
// ----------------------------------------------------------------------------
// table_driven_token_lexer_top
// Byte-stream lexer: input stage, byte queue and lexer core with token output.
// ----------------------------------------------------------------------------
// Path: the byte that completes a token passes the input stage register and
//   the byte queue before the core registers the token; a second token from
//   the same byte waits in the holding slot and follows it.
// Throughput: one byte per cycle while tokens are taken; the core holds its
//   input while a second token waits, and the four-entry byte queue absorbs the gap.
// Reset: clears all queues, returns the lexer to start mode, position zero.
module table_driven_token_lexer_top #(
    parameter int POSITION_BITS = tdl_pkg::DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = tdl_pkg::DEF_LENGTH_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tdl_pkg::TAG_W-1:0]     token_tag,
    output logic [tdl_pkg::OFFSET_W-1:0]  token_offset,
    output logic [tdl_pkg::LEN_W-1:0]     token_len,
    output logic                          last_of_run
);
    import tdl_pkg::*;

    logic   fr_valid;
    logic   fr_ready;
    item_t  fr_item;
    logic   q_valid;
    logic   q_ready;
    item_t  q_item;
    token_t tok;

    tdl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    tdl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    tdl_back #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_token (tok)
    );

    assign token_tag    = tok.tag;
    assign token_offset = tok.offset;
    assign token_len    = tok.len;
    assign last_of_run  = tok.last;

    // end of input always reports zero length
    a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_tag == TAG_EOF |-> token_len == '0)
        else $error("EOF token with nonzero length");

    // tags never leave the defined range
    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_tag <= TAG_ILLEGAL)
        else $error("token tag out of range");

    // keyword tags only come from spans of two to eight bytes
    a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_tag >= TAG_AND && token_tag <= TAG_WHILE
        |-> token_len >= LEN_W'(2) && token_len <= LEN_W'(KEYWORD_BYTES))
        else $error("keyword token with impossible length");

endmodule

// ===== tb/token_stream_check.sv =====
// ----------------------------------------------------------------------------
// token_stream_check
// Follows the byte and token channels of the lexer, works out the tokens
// that each accepted byte must produce and compares them in order with the
// tokens the block delivers.
// ----------------------------------------------------------------------------
module token_stream_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [tdl_pkg::TAG_W-1:0]     token_tag,
    input  logic [tdl_pkg::OFFSET_W-1:0]  token_offset,
    input  logic [tdl_pkg::LEN_W-1:0]     token_len,
    input  logic                          last_of_run,
    output int                            mismatch_count,
    output int                            tokens_owed
);

    import tdl_pkg::*;

    typedef enum logic [2:0] {
        LX_START,
        LX_IDENT,
        LX_MINUS,
        LX_NUMBER,
        LX_OPSPAN,
        LX_COMMENT
    } lex_mode_t;

    lex_mode_t   mode;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [7:0]  head [KEYWORD_BYTES];
    token_t      tokens_due [$];

    function automatic class_t char_class(input logic [7:0] b);
        class_t c;
        case (b) inside
            8'h00:                                   c = CL_NUL;
            8'h0A:                                   c = CL_NL;
            8'h09, " ":                              c = CL_BLANK;
            "#":                                     c = CL_HASH;
            "-":                                     c = CL_MINUS;
            ["0":"9"]:                               c = CL_DIGIT;
            ["a":"z"], ["A":"Z"], "_":               c = CL_ALPHA;
            "!", "$", "%", "&", "*", "+", "/", "<",
            "=", ">", "?", "@", "^", "|", "~":       c = CL_OP;
            "(", ")", ",", ".", ":", ";",
            "[", "]", "{", "}":                      c = CL_PUNCT;
            default:                                 c = CL_OTHER;
        endcase
        return c;
    endfunction

    // Pack the word right-aligned; identifier bytes are never zero, so the
    // packed value also pins the length.
    function automatic tag_t word_tag();
        logic [63:0] w;
        tag_t        t;
        w = '0;
        for (int i = 0; i < KEYWORD_BYTES; i++)
            if (i < int'(tok_len))
                w = {w[55:0], head[i]};
        if (tok_len > 16'd8)
            t = TAG_ID;
        else
        begin
            case (w)
                "do":       t = TAG_DO;
                "if":       t = TAG_IF;
                "or":       t = TAG_OR;
                "and":      t = TAG_AND;
                "end":      t = TAG_END;
                "for":      t = TAG_FOR;
                "let":      t = TAG_LET;
                "case":     t = TAG_CASE;
                "elif":     t = TAG_ELIF;
                "else":     t = TAG_ELSE;
                "then":     t = TAG_THEN;
                "while":    t = TAG_WHILE;
                "function": t = TAG_FUNCTION;
                default:    t = TAG_ID;
            endcase
        end
        return t;
    endfunction

    function automatic tag_t span_tag();
        tag_t t;
        t = TAG_ILLEGAL;
        if (tok_len == 16'd1)
        begin
            case (head[0])
                "=":     t = TAG_ASSIGN;
                "+":     t = TAG_ADD;
                "-":     t = TAG_SUB;
                "*":     t = TAG_MUL;
                "~":     t = TAG_NEG;
                "/":     t = TAG_DIV;
                "<":     t = TAG_LT;
                ">":     t = TAG_GT;
                default: t = TAG_ILLEGAL;
            endcase
        end
        else if (tok_len == 16'd2 && head[1] == "=")
        begin
            case (head[0])
                "=":     t = TAG_EQ;
                "!":     t = TAG_NE;
                "<":     t = TAG_LE;
                ">":     t = TAG_GE;
                default: t = TAG_ILLEGAL;
            endcase
        end
        return t;
    endfunction

    task automatic push_token(input tag_t t, input logic [31:0] off, input logic [15:0] n);
        token_t tok;
        tok.tag    = t;
        tok.offset = off;
        tok.len    = n;
        tok.last   = 1'b0;
        tokens_due.push_back(tok);
    endtask

    task automatic add_char(input logic [7:0] b);
        if (tok_len < 16'd8)
            head[tok_len[2:0]] = b;
        if (tok_len != 16'hFFFF)
            tok_len = tok_len + 16'd1;
    endtask

    task automatic open_token(input logic [7:0] b, input lex_mode_t m);
        tok_start = pos;
        tok_len   = '0;
        add_char(b);
        mode = m;
    endtask

    task automatic end_of_input();
        push_token(TAG_EOF, pos, 16'd0);
        pos     = '0;
        tok_len = '0;
        mode    = LX_START;
    endtask

    task automatic scan_start(input logic [7:0] b, input class_t c);
        tag_t t;
        case (c)
            CL_ALPHA: open_token(b, LX_IDENT);
            CL_DIGIT: open_token(b, LX_NUMBER);
            CL_MINUS: open_token(b, LX_MINUS);
            CL_OP:    open_token(b, LX_OPSPAN);
            CL_HASH:  mode = LX_COMMENT;
            CL_PUNCT:
            begin
                case (b)
                    ",":     t = TAG_COMMA;
                    ".":     t = TAG_DOT;
                    ":":     t = TAG_COLON;
                    ";":     t = TAG_SEMICOLON;
                    "{":     t = TAG_LBRACE;
                    "}":     t = TAG_RBRACE;
                    "[":     t = TAG_LBRACKET;
                    "]":     t = TAG_RBRACKET;
                    "(":     t = TAG_LPAREN;
                    ")":     t = TAG_RPAREN;
                    default: t = TAG_ILLEGAL;
                endcase
                push_token(t, pos, 16'd1);
            end
            CL_OTHER: push_token(TAG_ILLEGAL, pos, 16'd1);
            default: ;
        endcase
        // NUL resets the position instead of advancing it
        if (c == CL_NUL)
            end_of_input();
        else
            pos = pos + 32'd1;
    endtask

    task automatic lex_byte(input logic [7:0] b);
        class_t    c;
        logic      keep;
        lex_mode_t nxt;
        int        before_cnt;
        token_t    tail;
        c          = char_class(b);
        before_cnt = tokens_due.size();
        keep       = 1'b0;
        nxt        = LX_START;
        case (mode)
            LX_IDENT:
            begin
                keep = (c == CL_ALPHA || c == CL_DIGIT);
                nxt  = LX_IDENT;
            end
            LX_MINUS:
            begin
                if (c == CL_DIGIT)
                begin
                    keep = 1'b1;
                    nxt  = LX_NUMBER;
                end
                else if (c == CL_MINUS || c == CL_OP)
                begin
                    keep = 1'b1;
                    nxt  = LX_OPSPAN;
                end
            end
            LX_NUMBER:
            begin
                keep = (c == CL_DIGIT);
                nxt  = LX_NUMBER;
            end
            LX_OPSPAN:
            begin
                keep = (c == CL_MINUS || c == CL_OP);
                nxt  = LX_OPSPAN;
            end
            default: ;
        endcase

        if (mode == LX_COMMENT)
        begin
            if (c == CL_NUL)
                end_of_input();
            else
            begin
                if (c == CL_NL)
                    mode = LX_START;
                pos = pos + 32'd1;
            end
        end
        else if (mode == LX_START)
            scan_start(b, c);
        else if (keep)
        begin
            add_char(b);
            mode = nxt;
            pos  = pos + 32'd1;
        end
        else
        begin
            // close the pending token, then lex the delimiter again
            if (mode == LX_IDENT)
                push_token(word_tag(), tok_start, tok_len);
            else if (mode == LX_NUMBER)
                push_token(TAG_NUM, tok_start, tok_len);
            else
                push_token(span_tag(), tok_start, tok_len);
            mode = LX_START;
            scan_start(b, c);
        end

        if (tokens_due.size() > before_cnt)
        begin
            tail      = tokens_due.pop_back();
            tail.last = 1'b1;
            tokens_due.push_back(tail);
        end
    endtask

    task automatic check_token();
        token_t want;
        if (tokens_due.size() == 0)
        begin
            $display("%0t: token not expected: tag %0d offset %0d len %0d last %0b",
                     $time, token_tag, token_offset, token_len, last_of_run);
            mismatch_count++;
        end
        else
        begin
            want = tokens_due.pop_front();
            if (token_tag !== want.tag)
            begin
                $display("%0t: token_tag expected %0d, actual %0d", $time, want.tag, token_tag);
                mismatch_count++;
            end
            if (token_offset !== want.offset)
            begin
                $display("%0t: token_offset expected %0d, actual %0d",
                         $time, want.offset, token_offset);
                mismatch_count++;
            end
            if (token_len !== want.len)
            begin
                $display("%0t: token_len expected %0d, actual %0d", $time, want.len, token_len);
                mismatch_count++;
            end
            if (last_of_run !== want.last)
            begin
                $display("%0t: last_of_run expected %0b, actual %0b",
                         $time, want.last, last_of_run);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode      = LX_START;
            pos       = '0;
            tok_start = '0;
            tok_len   = '0;
            for (int i = 0; i < KEYWORD_BYTES; i++)
                head[i] = 8'h00;
            tokens_due.delete();
            mismatch_count = 0;
            tokens_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_token();
            if (in_valid && in_ready)
                lex_byte(in_byte);
            tokens_owed <= tokens_due.size();
        end
    end

endmodule

// ===== tb/tb_table_driven_token_lexer_top.sv =====
// ----------------------------------------------------------------------------
// tb_table_driven_token_lexer_top
// Feeds the lexer short directed byte strings, then random streams of
// keywords, names, numbers, operator spans, comments and noise, with random
// idle cycles on both channels, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_table_driven_token_lexer_top;

    import tdl_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_WORD   = 20;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          in_byte;
    logic                out_valid;
    logic                out_ready;
    logic [TAG_W-1:0]    token_tag;
    logic [OFFSET_W-1:0] token_offset;
    logic [LEN_W-1:0]    token_len;
    logic                last_of_run;

    int   mismatch_count;
    int   tokens_owed;
    int   bytes_sent;
    int   idle_cycles;
    int   in_pace;
    int   out_pace;
    logic hold_out;

    string keyword_list [13] = '{"do", "if", "or", "and", "end", "for", "let", "case",
                                 "elif", "else", "then", "while", "function"};
    string op_list [12]      = '{"=", "+", "-", "*", "~", "/", "<", ">",
                                 "==", "!=", "<=", ">="};
    string span_chars        = "!$%&*+/<=>?@^|~-";
    string punct_chars       = ",.:;{}[]()";

    table_driven_token_lexer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_tag    (token_tag),
        .token_offset (token_offset),
        .token_len    (token_len),
        .last_of_run  (last_of_run)
    );

    token_stream_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_tag      (token_tag),
        .token_offset   (token_offset),
        .token_len      (token_len),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .tokens_owed    (tokens_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pace 0: no idling, 1: occasional waits, 2: a random wait drawn for every request
    function automatic int draw_wait(input int pace);
        int w;
        w = 0;
        if (pace == 2 || (pace == 1 && $urandom_range(0, 3) == 0))
            w = $urandom_range(0, 18);
        return w;
    endfunction

    function automatic logic [7:0] word_char(input logic lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(in_pace);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (tokens_owed == 0);
        @(posedge clk);
    endtask

    task automatic put_lexeme();
        int kind;
        int r;
        kind = $urandom_range(0, 19);
        if (kind < 4)
        begin
            put_text(keyword_list[$urandom_range(0, 12)]);
            // spoil the keyword now and then
            if ($urandom_range(0, 3) == 0)
                put_byte(word_char(1'b0));
        end
        else if (kind < 7)
        begin
            put_byte(word_char(1'b1));
            repeat ($urandom_range(0, 9))
                put_byte(word_char(1'b0));
        end
        else if (kind < 9)
        begin
            if ($urandom_range(0, 2) == 0)
                put_byte("-");
            repeat ($urandom_range(1, 5))
                put_byte(8'("0" + $urandom_range(0, 9)));
        end
        else if (kind < 12)
            put_text(op_list[$urandom_range(0, 11)]);
        else if (kind < 13)
        begin
            repeat ($urandom_range(1, 3))
                put_byte(span_chars[$urandom_range(0, 15)]);
        end
        else if (kind < 15)
            put_byte(punct_chars[$urandom_range(0, 9)]);
        else if (kind < 16)
        begin
            put_byte("#");
            repeat ($urandom_range(0, 6))
            begin
                r = $urandom_range(1, 255);
                put_byte(r == 10 ? "x" : 8'(r));
            end
            put_byte(($urandom_range(0, 4) == 0) ? 8'h00 : 8'h0A);
        end
        else if (kind < 19)
            put_byte(8'($urandom_range(0, 255)));
        else
            put_byte(8'h00);

        case ($urandom_range(0, 5))
            2:       put_byte(" ");
            3:       put_byte(8'h09);
            4:       put_byte(8'h0A);
            5:       put_byte(punct_chars[$urandom_range(0, 9)]);
            default: ;
        endcase
    endtask

    task automatic put_random(input int count, input int ipace, input int opace);
        int first_sent;
        first_sent = bytes_sent;
        in_pace    = ipace;
        out_pace   = opace;
        while (bytes_sent - first_sent < count)
            put_lexeme();
    endtask

    // output side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            stall = draw_wait(out_pace);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_byte     <= 8'h00;
        idle_cycles = 0;
        bytes_sent  = 0;
        in_pace     = 0;
        out_pace    = 0;
        hold_out    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // EOF at offset zero, minus-number closed by punctuation, bad spans,
        // comment end, stray bytes, lone minus, NUL inside a comment
        put_byte(8'h00);
        put_text("-42;!= <<=- #q");
        put_byte(8'h0A);
        put_byte(8'hFF);
        put_byte(8'h01);
        put_text("\"- #z");
        put_byte(8'h00);

        put_random(200, 2, 2);
        drain();

        // stall the output so the queues fill and back up the input
        in_pace  = 0;
        hold_out = 1'b1;
        repeat (40) put_byte(";");
        drain();

        put_random(200, 0, 1);

        // one name longer than any keyword
        in_pace  = 0;
        out_pace = 2;
        put_byte(word_char(1'b1));
        repeat (LONG_WORD - 1) put_byte(word_char(1'b0));
        put_byte(" ");

        put_random(160, 1, 0);
        put_byte(8'h00);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
